### rtl/core/rvbr_pkg.sv
`timescale 1ns / 1ps

package rvbr_pkg;

  // Byte store geometry
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field and state widths
  localparam int ACC_W   = 40;
  localparam int VB_W    = 6;
  localparam int IDX_W   = 14;
  localparam int LEN_W   = 13;
  localparam int CNT_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int OUT_W   = 32;

  // Bit count ceiling and refill threshold
  localparam logic [CNT_W-1:0] MAX_COUNT  = 6'd32;
  localparam logic [VB_W-1:0]  FILL_LIMIT = 6'd32;

  // Unstuffing constants
  localparam logic [6:0]        LOW7_ONES = 7'h7F;
  localparam logic [BYTE_W-1:0] STUFF_MIN = 8'h8F;
  localparam logic [3:0]        NIB_STUFF = 4'h8;
  localparam logic [2:0]        NIB_LOW3  = 3'h7;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_READ  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SERVE,
    ST_FILL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic mem_wr;      // write the load item's byte
    logic seg_init;    // capture offset and length, clear accumulator
    logic req_init;    // capture clamped bit count and operation
    logic nib_apply;   // take the first nibble
    logic byte_apply;  // append one byte (or a zero byte)
    logic emit;        // load the output register, consume on read
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_valid;   // read index points inside the buffer
    logic need_fill;   // fewer valid bits than requested
    logic fill_more;   // still at or below the refill threshold
  } status_t;

endpackage

### rtl/core/rvbr_ifs.sv
`timescale 1ns / 1ps

interface rvbr_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [rvbr_pkg::ADDR_W-1:0]       byte_addr;
  logic [rvbr_pkg::BYTE_W-1:0]       byte_value;
  logic [11:0]                       segment_offset;
  logic [rvbr_pkg::LEN_W-1:0]        buffer_length;
  logic [rvbr_pkg::CNT_W-1:0]        bit_count;

  modport source (
    output valid, req_type, byte_addr, byte_value, segment_offset, buffer_length, bit_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_addr, byte_value, segment_offset, buffer_length, bit_count,
    output ready
  );
endinterface

interface rvbr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rvbr_pkg::OUT_W-1:0]  bits_out;

  modport source (output valid, bits_out, input ready);
  modport sink   (input valid, bits_out, output ready);
endinterface

### rtl/core/rvbr_ctrl.sv
`timescale 1ns / 1ps

module rvbr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  rvbr_pkg::req_type_t req_type,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  rvbr_pkg::status_t   status,
  output rvbr_pkg::cmd_t      cmd
);

  rvbr_pkg::state_t state, state_next;
  logic             out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rvbr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      rvbr_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_type)
            rvbr_pkg::REQ_LOAD: cmd.mem_wr = 1'b1;
            rvbr_pkg::REQ_START: begin
              cmd.seg_init = 1'b1;
              state_next   = rvbr_pkg::ST_START;
            end
            rvbr_pkg::REQ_PEEK, rvbr_pkg::REQ_READ: begin
              cmd.req_init = 1'b1;
              state_next   = rvbr_pkg::ST_SERVE;
            end
          endcase
        end
      end
      rvbr_pkg::ST_START: begin
        cmd.nib_apply = status.idx_valid;
        state_next    = rvbr_pkg::ST_IDLE;
      end
      rvbr_pkg::ST_SERVE: begin
        priority if (status.need_fill) begin
          state_next = rvbr_pkg::ST_FILL;
        end else if (!out_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = rvbr_pkg::ST_IDLE;
        end
      end
      rvbr_pkg::ST_FILL: begin
        if (status.fill_more) begin
          cmd.byte_apply = 1'b1;
        end else begin
          state_next = rvbr_pkg::ST_SERVE;
        end
      end
    endcase
  end

  // Hold the result until taken; a new one may replace it in the same cycle
  always_comb begin
    out_valid_next = out_valid;
    if (rsp_ready) out_valid_next = 1'b0;
    if (cmd.emit)  out_valid_next = 1'b1;
  end

  assign rsp_valid = out_valid;

endmodule

### rtl/core/rvbr_datapath.sv
`timescale 1ns / 1ps

module rvbr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rvbr_pkg::cmd_t                    cmd,
  input  logic [1:0]                        req_type,
  input  logic [rvbr_pkg::ADDR_W-1:0]       byte_addr,
  input  logic [rvbr_pkg::BYTE_W-1:0]       byte_value,
  input  logic [11:0]                       segment_offset,
  input  logic [rvbr_pkg::LEN_W-1:0]        buffer_length,
  input  logic [rvbr_pkg::CNT_W-1:0]        bit_count,
  output rvbr_pkg::status_t                 status,
  output logic [rvbr_pkg::OUT_W-1:0]        bits_out
);

  logic [rvbr_pkg::BYTE_W-1:0] mem [rvbr_pkg::STORE_DEPTH];
  logic [rvbr_pkg::BYTE_W-1:0] rd_data;

  logic [rvbr_pkg::ACC_W-1:0]  acc, acc_next;
  logic [rvbr_pkg::VB_W-1:0]   vb, vb_next;
  logic                        stuff, stuff_next;
  logic [rvbr_pkg::IDX_W-1:0]  read_index, read_index_next;
  logic [rvbr_pkg::LEN_W-1:0]  valid_length, valid_length_next;
  logic [rvbr_pkg::CNT_W-1:0]  count;
  logic                        consume;
  logic [rvbr_pkg::OUT_W-1:0]  out_data;

  logic                        idx_valid;
  logic [3:0]                  nib;
  logic                        nib_drop;
  logic [rvbr_pkg::BYTE_W-1:0] fbyte;
  logic                        byte_drop;
  logic [rvbr_pkg::BYTE_W-1:0] byte_kept;
  logic [rvbr_pkg::ACC_W-1:0]  byte_placed;
  logic [rvbr_pkg::ACC_W-1:0]  mask;

  // Store: the read address follows the index of the coming cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[byte_addr] <= byte_value;
    rd_data <= mem[read_index_next[rvbr_pkg::ADDR_W-1:0]];
  end

  assign idx_valid = !read_index[rvbr_pkg::IDX_W-1] &&
                     (read_index[rvbr_pkg::LEN_W-1:0] < valid_length);

  assign nib      = rd_data[7:4];
  assign nib_drop = (nib[2:0] == rvbr_pkg::NIB_LOW3);

  assign fbyte       = idx_valid ? rd_data : '0;
  assign byte_drop   = stuff && (fbyte[6:0] == rvbr_pkg::LOW7_ONES);
  assign byte_kept   = byte_drop ? {1'b0, fbyte[6:0]} : fbyte;
  assign byte_placed = {{(rvbr_pkg::ACC_W-rvbr_pkg::BYTE_W){1'b0}}, byte_kept} << vb;

  assign mask = ({{(rvbr_pkg::ACC_W-1){1'b0}}, 1'b1} << count) - {{(rvbr_pkg::ACC_W-1){1'b0}}, 1'b1};

  always_comb begin
    acc_next          = acc;
    vb_next           = vb;
    stuff_next        = stuff;
    read_index_next   = read_index;
    valid_length_next = valid_length;
    if (cmd.seg_init) begin
      acc_next          = '0;
      vb_next           = '0;
      stuff_next        = 1'b0;
      valid_length_next = buffer_length;
      read_index_next   = {2'b00, segment_offset} - 14'd2;
    end
    if (cmd.nib_apply) begin
      acc_next        = {{(rvbr_pkg::ACC_W-4){1'b0}}, nib_drop ? {1'b0, nib[2:0]} : nib};
      vb_next         = nib_drop ? 6'd3 : 6'd4;
      stuff_next      = (nib > rvbr_pkg::NIB_STUFF);
      read_index_next = read_index - 14'd1;
    end
    if (cmd.byte_apply) begin
      acc_next   = acc | byte_placed;
      vb_next    = vb + 6'd8 - {5'd0, byte_drop};
      stuff_next = (fbyte > rvbr_pkg::STUFF_MIN);
      if (idx_valid) read_index_next = read_index - 14'd1;
    end
    if (cmd.emit && consume) begin
      acc_next = acc >> count;
      vb_next  = vb - count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      vb           <= '0;
      stuff        <= 1'b0;
      read_index   <= '1;
      valid_length <= '0;
    end else begin
      acc          <= acc_next;
      vb           <= vb_next;
      stuff        <= stuff_next;
      read_index   <= read_index_next;
      valid_length <= valid_length_next;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.req_init) begin
      count   <= (bit_count > rvbr_pkg::MAX_COUNT) ? rvbr_pkg::MAX_COUNT : bit_count;
      consume <= (req_type == rvbr_pkg::REQ_READ);
    end
    if (cmd.emit) out_data <= acc[rvbr_pkg::OUT_W-1:0] & mask[rvbr_pkg::OUT_W-1:0];
  end

  assign status.idx_valid = idx_valid;
  assign status.need_fill = (vb < count);
  assign status.fill_more = (vb <= rvbr_pkg::FILL_LIMIT);
  assign bits_out         = out_data;

endmodule

### rtl/core/reverse_vlc_bit_reader.sv
`timescale 1ns / 1ps

// Reverse VLC bit reader for an HTJ2K code-block segment.
// Channel req (sink): one item per request, selected by req_type: load writes
// byte_value at byte_addr into the 4096-byte store, start sets up a segment
// (first byte at segment_offset-2, buffer_length valid bytes), peek and read
// return the low bit_count bits (clamped to 32) on channel rsp (source).
// Load and start give no result item; peek and read give exactly one.
// A load writes the store when accepted; a start takes the first nibble, if it
// lies in the buffer, in the start step. A peek or read is served in the serve
// step; one that needs a refill first passes the fill step, appending at most 5 bytes, one per cycle,
// set by the single read port of the byte store. Items are taken one at a time.
// The result sits in an output register, so the next item is accepted while
// it waits; a second peek or read holds in the serve step until rsp is free.
// Reset (synchronous, rst high) clears the accumulator, bit count and
// unstuffing flag and marks the stream exhausted; the store is not cleared
// and must be loaded before it is read.

module reverse_vlc_bit_reader (
  input  logic             clk,
  input  logic             rst,
  rvbr_req_if.sink         req,
  rvbr_rsp_if.source       rsp
);

  rvbr_pkg::cmd_t    cmd;
  rvbr_pkg::status_t status;

  // Sequence requests and own the result handshake
  rvbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (rvbr_pkg::req_type_t'(req.req_type)),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, accumulator and unstuffing logic
  rvbr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req.req_type),
    .byte_addr      (req.byte_addr),
    .byte_value     (req.byte_value),
    .segment_offset (req.segment_offset),
    .buffer_length  (req.buffer_length),
    .bit_count      (req.bit_count),
    .status         (status),
    .bits_out       (rsp.bits_out)
  );

endmodule

### sim/reverse_vlc_bit_reader_tb.sv
`timescale 1ns / 1ps

module reverse_vlc_bit_reader_tb;
  import rvbr_pkg::*;

  // Predictor sides: GEN shadows the stream while items are generated,
  // CHK follows the items as the block accepts them.
  localparam int GEN = 0;
  localparam int CHK = 1;

  localparam int RANDOM_ITEMS  = 650;
  localparam int DIRECTED_MAX  = 25;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    int               vbits;
    bit               stuff;
    int               ridx;
    int               vlen;
  } reader_t;

  typedef struct packed {
    logic              drain;  // hold this item until every result is back
    req_type_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [11:0]       offset;
    logic [LEN_W-1:0]  length;
    logic [CNT_W-1:0]  count;
  } bits_req_t;

  logic clk;
  logic rst;

  rvbr_req_if req_ch ();
  rvbr_rsp_if rsp_ch ();

  reverse_vlc_bit_reader dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  reader_t           rd [2];
  logic [BYTE_W-1:0] store [2][STORE_DEPTH];
  bit                written [STORE_DEPTH];  // generator side only

  bits_req_t         req_backlog [$];
  logic [OUT_W-1:0]  bits_due [$];
  bit                drain_next;
  int                items_total;
  int                items_taken;
  int                errors;
  int                tx_gap;
  int                rx_stall;
  bit                calm_tx;
  bit                calm_rx;

  // ---------------------------------------------------------------------------
  // Bit reader predictor
  // ---------------------------------------------------------------------------

  function automatic bit idx_ok(int side);
    return rd[side].ridx >= 0 && rd[side].ridx < rd[side].vlen;
  endfunction

  // Append bytes until more than FILL_LIMIT bits are held. On the generator
  // side, stop at the first store entry never written and return its address.
  function automatic int fill_reader(int side);
    logic [BYTE_W-1:0] b;
    bit                drop;
    int                a;
    while (rd[side].vbits <= int'(FILL_LIMIT)) begin
      b = '0;
      if (idx_ok(side)) begin
        a = rd[side].ridx % STORE_DEPTH;
        if (side == GEN && !written[a]) return a;
        b = store[side][a];
        rd[side].ridx = rd[side].ridx - 1;
      end
      // unstuff: drop bit 7 after a byte above STUFF_MIN when the low seven are ones
      drop = rd[side].stuff && (b[6:0] == LOW7_ONES);
      rd[side].acc = rd[side].acc |
                     (ACC_W'(drop ? {1'b0, b[6:0]} : b) << rd[side].vbits);
      rd[side].vbits = rd[side].vbits + (drop ? 7 : 8);
      rd[side].stuff = b > STUFF_MIN;
    end
    return -1;
  endfunction

  function automatic int start_segment(int side, int off, int len);
    logic [3:0] nib;
    bit         drop;
    int         a;
    rd[side]      = '0;
    rd[side].vlen = len;
    rd[side].ridx = off - 2;
    if (idx_ok(side)) begin
      a = rd[side].ridx % STORE_DEPTH;
      if (side == GEN && !written[a]) return a;
      // take the high nibble; a nibble with its low three bits set loses bit 3
      nib  = store[side][a][7:4];
      drop = nib[2:0] == NIB_LOW3;
      rd[side].acc   = ACC_W'(drop ? {1'b0, nib[2:0]} : nib);
      rd[side].vbits = drop ? 3 : 4;
      rd[side].stuff = nib > NIB_STUFF;
      rd[side].ridx  = rd[side].ridx - 1;
    end
    return -1;
  endfunction

  function automatic logic [OUT_W-1:0] take_bits(int side, req_type_t kind, int cnt);
    int               n;
    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] value;
    n = (cnt > int'(MAX_COUNT)) ? int'(MAX_COUNT) : cnt;
    if (rd[side].vbits < n) void'(fill_reader(side));
    mask  = (ACC_W'(1) << n) - ACC_W'(1);
    value = rd[side].acc & mask;
    if (kind == REQ_READ) begin
      rd[side].acc   = rd[side].acc >> n;
      rd[side].vbits = rd[side].vbits - n;
    end
    return OUT_W'(value);
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  // Unused fields carry random values; the block must ignore them.
  function automatic bits_req_t random_fields(req_type_t kind);
    bits_req_t it;
    it.drain  = drain_next;
    it.kind   = kind;
    it.addr   = ADDR_W'($urandom);
    it.value  = BYTE_W'($urandom);
    it.offset = 12'($urandom);
    it.length = LEN_W'($urandom_range(0, STORE_DEPTH));
    it.count  = CNT_W'($urandom_range(0, 32));
    drain_next = 1'b0;
    return it;
  endfunction

  // Segment content leaning toward the stuffing patterns.
  function automatic logic [BYTE_W-1:0] stream_byte();
    case ($urandom_range(0, 9))
      0:       return 8'hFF;
      1:       return 8'h7F;
      2:       return BYTE_W'($urandom_range(8'h90, 8'hFF));
      3:       return 8'h8F;
      4:       return 8'h90;
      5:       return 8'h00;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic int count_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 12) return 32;
    if (r < 16) return $urandom_range(33, 63);
    return $urandom_range(1, 31);
  endfunction

  function automatic int gap_length(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void load_byte(int a, logic [BYTE_W-1:0] v);
    bits_req_t it;
    it       = random_fields(REQ_LOAD);
    it.addr  = ADDR_W'(a);
    it.value = v;
    store[GEN][a % STORE_DEPTH] = v;
    written[a % STORE_DEPTH]    = 1'b1;
    req_backlog.push_back(it);
  endfunction

  // Load the first byte if it was never written, then queue the start.
  function automatic void start_seg(int off, int len);
    bits_req_t it;
    int        miss;
    miss = start_segment(GEN, off, len);
    while (miss >= 0) begin
      load_byte(miss, stream_byte());
      miss = start_segment(GEN, off, len);
    end
    it        = random_fields(REQ_START);
    it.offset = 12'(off);
    it.length = LEN_W'(len);
    req_backlog.push_back(it);
  endfunction

  // Load every byte the refill would fetch unwritten, then queue the request.
  function automatic void ask_bits(req_type_t kind, int cnt);
    bits_req_t it;
    reader_t   saved;
    int        n;
    int        miss;
    saved = rd[GEN];
    n     = (cnt > int'(MAX_COUNT)) ? int'(MAX_COUNT) : cnt;
    miss  = (rd[GEN].vbits < n) ? fill_reader(GEN) : -1;
    while (miss >= 0) begin
      rd[GEN] = saved;
      load_byte(miss, stream_byte());
      miss = fill_reader(GEN);
    end
    rd[GEN] = saved;
    void'(take_bits(GEN, kind, cnt));
    it       = random_fields(kind);
    it.count = CNT_W'(cnt);
    req_backlog.push_back(it);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and stimulus
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("reverse_vlc_bit_reader_tb: FAIL");
    $finish;
  end

  initial begin
    int choice;
    int off;
    int len;
    int pre;
    int i;
    int nreq;

    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_LOAD;
    req_ch.byte_addr      = '0;
    req_ch.byte_value     = '0;
    req_ch.segment_offset = '0;
    req_ch.buffer_length  = '0;
    req_ch.bit_count      = '0;
    rsp_ch.ready          = 1'b0;
    errors                = 0;
    items_taken           = 0;
    drain_next            = 1'b0;
    for (i = 0; i < 2; i++) begin
      rd[i]      = '0;
      rd[i].ridx = -1;  // stream exhausted after reset
    end

    // Directed: after reset the stream is exhausted, so zeros come back.
    ask_bits(REQ_PEEK, 32);
    // First nibble 0xF loses its top bit and arms stuffing; 0xFF after it
    // and 0x7F after 0x95 both lose bit 7.
    load_byte(5, 8'hF3);
    load_byte(4, 8'hFF);
    load_byte(3, 8'h95);
    load_byte(2, 8'h7F);
    load_byte(1, 8'h00);
    load_byte(0, 8'hA5);
    start_seg(7, 6);
    ask_bits(REQ_PEEK, 0);
    ask_bits(REQ_READ, 3);
    ask_bits(REQ_PEEK, 32);
    ask_bits(REQ_READ, 32);
    ask_bits(REQ_READ, 63);  // clamp, then run into the exhausted stream
    ask_bits(REQ_READ, 33);
    // Nibble 7 at the top of the store: three bits kept, no stuffing.
    load_byte(STORE_DEPTH - 3, 8'h7C);
    start_seg(STORE_DEPTH - 1, STORE_DEPTH);
    ask_bits(REQ_READ, 32);
    // Nibble 9: four bits kept, stuffing armed.
    load_byte(9, 8'h9E);
    start_seg(11, 10);
    ask_bits(REQ_READ, 5);
    ask_bits(REQ_PEEK, 20);
    // Start below the store, beyond the buffer, and with an empty buffer.
    start_seg(1, STORE_DEPTH);
    ask_bits(REQ_READ, 8);
    start_seg(10, 8);
    ask_bits(REQ_PEEK, 16);
    start_seg(3, 0);
    ask_bits(REQ_READ, 12);

    // Hold the first random item until the directed results are all back.
    drain_next = 1'b1;

    while (req_backlog.size() < DIRECTED_MAX + RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        // Well-formed segment: lay out bytes below the start, start, then
        // pull bits. Most segments sit low so that reads reach the end.
        off = ($urandom_range(0, 2) == 0) ? $urandom_range(2, STORE_DEPTH - 1)
                                          : $urandom_range(2, 40);
        len = ($urandom_range(0, 4) == 0) ? STORE_DEPTH
                                          : $urandom_range(off - 1, STORE_DEPTH);
        pre = $urandom_range(0, 12);
        for (i = 0; i < pre && off - 2 - i >= 0; i++)
          load_byte(off - 2 - i, stream_byte());
        if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
        start_seg(off, len);
        nreq = $urandom_range(2, 10);
        for (i = 0; i < nreq; i++)
          ask_bits($urandom_range(0, 1) ? REQ_READ : REQ_PEEK, count_pick());
      end else if (choice < 82) begin
        // Stray loads anywhere in the store.
        nreq = $urandom_range(1, 4);
        for (i = 0; i < nreq; i++)
          load_byte($urandom_range(0, STORE_DEPTH - 1), BYTE_W'($urandom));
      end else if (choice < 92) begin
        // Broken start: first byte below the store or outside the buffer.
        if ($urandom_range(0, 1)) begin
          start_seg($urandom_range(0, 1), $urandom_range(0, STORE_DEPTH));
        end else begin
          off = $urandom_range(2, STORE_DEPTH - 1);
          start_seg(off, $urandom_range(0, off - 2));
        end
        nreq = $urandom_range(1, 3);
        for (i = 0; i < nreq; i++)
          ask_bits($urandom_range(0, 1) ? REQ_READ : REQ_PEEK, count_pick());
      end else begin
        // Keep pulling from whatever segment is current.
        nreq = $urandom_range(1, 4);
        for (i = 0; i < nreq; i++)
          ask_bits($urandom_range(0, 1) ? REQ_READ : REQ_PEEK, count_pick());
      end
    end
    items_total = req_backlog.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, every result to arrive, then settle
    // long enough for a stray result to show up.
    while (items_taken != items_total) @(posedge clk);
    while (bits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("reverse_vlc_bit_reader_tb: PASS");
    end else begin
      $display("reverse_vlc_bit_reader_tb: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: predict each accepted item, then present the next one
  // after a random gap. A drain item waits until no result is outstanding.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    bits_req_t nxt;
    req_type_t kind;
    if (rst) begin
      req_ch.valid <= 1'b0;
      tx_gap        = 0;
      calm_tx       = 1'b0;
    end else begin
      // toggle stretches with no idling
      if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;

      if (req_ch.valid && req_ch.ready) begin
        kind = req_type_t'(req_ch.req_type);
        case (kind)
          REQ_LOAD: begin
            store[CHK][int'(req_ch.byte_addr) % STORE_DEPTH] = req_ch.byte_value;
          end
          REQ_START: begin
            void'(start_segment(CHK, int'(req_ch.segment_offset),
                                int'(req_ch.buffer_length)));
          end
          default: begin
            bits_due.push_back(take_bits(CHK, kind, int'(req_ch.bit_count)));
          end
        endcase
        items_taken++;
      end

      // advance only when the current item is gone or none is shown
      if (!req_ch.valid || req_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() != 0 &&
                     !(req_backlog[0].drain && bits_due.size() != 0)) begin
          nxt = req_backlog.pop_front();
          req_ch.valid          <= 1'b1;
          req_ch.req_type       <= nxt.kind;
          req_ch.byte_addr      <= nxt.addr;
          req_ch.byte_value     <= nxt.value;
          req_ch.segment_offset <= nxt.offset;
          req_ch.buffer_length  <= nxt.length;
          req_ch.bit_count      <= nxt.count;
          tx_gap = gap_length(calm_tx);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each result with the oldest expectation, stall
  // at random after a result and now and then while waiting.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_stall      = 0;
      calm_rx       = 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;

      if (rsp_ch.valid && rsp_ch.ready) begin
        if (bits_due.size() == 0) begin
          errors++;
          $display("%0t: bits_out expected none, actual %h", $time, rsp_ch.bits_out);
        end else begin
          want = bits_due.pop_front();
          if (rsp_ch.bits_out !== want) begin
            errors++;
            $display("%0t: bits_out expected %h, actual %h",
                     $time, want, rsp_ch.bits_out);
          end
        end
        rx_stall = gap_length(calm_rx);
      end else if (rx_stall == 0 && $urandom_range(0, 15) == 0) begin
        rx_stall = gap_length(calm_rx);
      end

      if (rx_stall > 0) begin
        rx_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

endmodule

### sim.f
rtl/core/rvbr_pkg.sv
rtl/core/rvbr_ifs.sv
rtl/core/rvbr_ctrl.sv
rtl/core/rvbr_datapath.sv
rtl/core/reverse_vlc_bit_reader.sv
sim/reverse_vlc_bit_reader_tb.sv
